[sv/bfb_count_vector_decider_assert.svh]
// ---------------------------------------------------------------------------
// BFB count vector decider assertion macros
// Clocked property checks on aclk; BCVD_ASSERT is masked while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef BFB_COUNT_VECTOR_DECIDER_ASSERT_SVH
`define BFB_COUNT_VECTOR_DECIDER_ASSERT_SVH
`ifndef SYNTHESIS
`define BCVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BCVD_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BCVD_ASSERT(label, prop, msg)
`define BCVD_ASSERT_ANY(label, prop, msg)
`endif
`endif

[sv/bcvd_pkg.sv]
// ---------------------------------------------------------------------------
// BFB count vector decider package
// Sizes, controller command and status types, fold arithmetic helpers.
// ---------------------------------------------------------------------------
package bcvd_pkg;

    localparam int SIG_DEPTH  = 24;
    localparam int COUNT_BITS = 16;
    localparam int SIG_W      = 18;
    localparam int IW         = $clog2(SIG_DEPTH);
    localparam int CW         = $clog2(SIG_DEPTH + 1);
    localparam int DW         = 60;

    localparam logic signed [DW-1:0] ENTRY_MAX = DW'(131071);
    localparam logic signed [DW-1:0] ENTRY_MIN = -DW'(131072);
    localparam logic [DW-1:0]        PROD_LIM  = DW'(64'd1 << 50);

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_ZERO, OP_SUB, OP_ADJ, OP_UPNUM, OP_CMP,
        OP_WR, OP_WRZ, OP_SETTOP, OP_TRIMDEC, OP_FAIL, OP_FINISH, OP_PINIT,
        OP_PINC, OP_RESULT
    } op_t;

    typedef enum logic [2:0] {
        RS_D, RS_DM1, RS_TOP, RS_TOPM1, RS_ZERO
    } rsel_t;

    typedef struct packed {
        op_t   op;
        rsel_t rsel;
        logic  res_val;
    } cmd_t;

    typedef struct packed {
        logic eq;
        logic up;
        logic bad;
        logic r_lt_dv;
        logic d_gt_dv;
        logic d_eq_dv;
        logic d_zero;
        logic brk;
        logic top_gt0;
        logic rd_zero;
        logic rd_le0;
        logic rd_gt1;
        logic n_is1;
        logic scan_cont;
        logic ge;
        logic failed;
        logic last;
        logic out_busy;
    } stat_t;

    // v * 2^k, saturated
    function automatic logic signed [DW-1:0] mulp(input logic [SIG_W-1:0] v,
                                                  input logic [CW-1:0] k);
        logic [DW-1:0] s;
        s = DW'(v) << k;
        if (v == '0) return '0;
        if (32'(k) >= 40) return signed'(PROD_LIM);
        if (s > PROD_LIM) return signed'(PROD_LIM);
        return signed'(s);
    endfunction

    // x / 2^k, truncating toward zero
    function automatic logic signed [DW-1:0] divp(input logic signed [DW-1:0] x,
                                                  input logic [CW-1:0] k);
        logic [DW-1:0] m;
        m = -x;
        m = m >> k;
        if (32'(k) >= 62) return '0;
        if (!x[DW-1]) return x >>> k;
        return -signed'(m);
    endfunction

    function automatic logic signed [SIG_W-1:0] sat(input logic signed [DW-1:0] x);
        if (x > ENTRY_MAX) return SIG_W'(ENTRY_MAX);
        if (x < ENTRY_MIN) return SIG_W'(ENTRY_MIN);
        return SIG_W'(x);
    endfunction

    function automatic logic [SIG_W-1:0] absv(input logic signed [SIG_W-1:0] v);
        return v[SIG_W-1] ? SIG_W'(-v) : SIG_W'(v);
    endfunction

    function automatic logic [CW-1:0] tz(input logic [COUNT_BITS-1:0] m);
        logic [CW-1:0] z;
        z = '0;
        for (int i = COUNT_BITS - 1; i >= 0; i--) begin
            if (m[i]) z = CW'(i);
        end
        return z;
    endfunction

endpackage

[sv/bcvd_ctrl.sv]
// ---------------------------------------------------------------------------
// BFB count vector decider controller
// Sequences the fold, trim and palindrome steps over the datapath.
// ---------------------------------------------------------------------------
module bcvd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output bcvd_pkg::cmd_t  cmd,
    input  bcvd_pkg::stat_t stat
);
    import bcvd_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE   = 23'd1 << 0,
        S_START  = 23'd1 << 1,
        S_ZERO   = 23'd1 << 2,
        S_SUB    = 23'd1 << 3,
        S_DIR    = 23'd1 << 4,
        S_UPADJ  = 23'd1 << 5,
        S_UPNUM  = 23'd1 << 6,
        S_UPWR   = 23'd1 << 7,
        S_UPTOP  = 23'd1 << 8,
        S_SRCH   = 23'd1 << 9,
        S_SRCHS  = 23'd1 << 10,
        S_ADJ    = 23'd1 << 11,
        S_CMP    = 23'd1 << 12,
        S_WR     = 23'd1 << 13,
        S_WRZ    = 23'd1 << 14,
        S_TRIMI  = 23'd1 << 15,
        S_TRIMA  = 23'd1 << 16,
        S_TRIMB  = 23'd1 << 17,
        S_FAIL   = 23'd1 << 18,
        S_FIN    = 23'd1 << 19,
        S_PAL0   = 23'd1 << 20,
        S_SCAN   = 23'd1 << 21,
        S_RES    = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;
    logic   val_reg, val_next;
    logic   scan_reg, scan_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        val_next    = val_reg;
        scan_next   = scan_reg;
        cmd.op      = OP_NONE;
        cmd.rsel    = RS_D;
        cmd.res_val = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.op = OP_START;
                if (stat.failed || stat.eq) state_next = S_FIN;
                else if (stat.bad)          state_next = S_FAIL;
                else if (stat.r_lt_dv)      state_next = S_ZERO;
                else                        state_next = S_SUB;
            end
            S_ZERO: begin
                cmd.op = OP_ZERO;
                if (stat.d_eq_dv) state_next = S_DIR;
            end
            S_SUB: begin
                cmd.rsel = RS_DM1;
                if (stat.d_gt_dv) cmd.op = OP_SUB;
                else              state_next = S_DIR;
            end
            S_DIR: begin
                state_next = stat.up ? S_UPADJ : S_SRCH;
            end
            S_UPADJ: begin
                cmd.op     = OP_ADJ;
                state_next = S_UPNUM;
            end
            S_UPNUM: begin
                cmd.op     = OP_UPNUM;
                state_next = S_UPWR;
            end
            S_UPWR: begin
                cmd.op     = OP_WR;
                state_next = S_UPTOP;
            end
            S_UPTOP: begin
                cmd.op     = OP_SETTOP;
                state_next = S_FIN;
            end
            S_SRCH: begin
                if (stat.brk)         state_next = S_ADJ;
                else if (stat.d_zero) state_next = S_FAIL;
                else                  state_next = S_SRCHS;
            end
            S_SRCHS: begin
                cmd.rsel   = RS_DM1;
                cmd.op     = OP_SUB;
                state_next = S_SRCH;
            end
            S_ADJ: begin
                cmd.op     = OP_ADJ;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.op     = OP_CMP;
                state_next = S_WR;
            end
            S_WR: begin
                cmd.op     = OP_WR;
                state_next = stat.ge ? S_TRIMI : S_WRZ;
            end
            S_WRZ: begin
                cmd.op     = OP_WRZ;
                state_next = S_TRIMI;
            end
            S_TRIMI: begin
                cmd.op     = OP_SETTOP;
                state_next = S_TRIMA;
            end
            S_TRIMA: begin
                cmd.rsel   = RS_TOP;
                state_next = (stat.top_gt0 && stat.rd_zero) ? S_TRIMB : S_FIN;
            end
            S_TRIMB: begin
                cmd.rsel = RS_TOPM1;
                if (stat.rd_le0) begin
                    cmd.op     = OP_TRIMDEC;
                    state_next = S_TRIMA;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FAIL: begin
                cmd.op     = OP_FAIL;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.op     = OP_FINISH;
                state_next = stat.last ? S_PAL0 : S_IDLE;
            end
            S_PAL0: begin
                cmd.rsel   = RS_ZERO;
                scan_next  = 1'b0;
                state_next = S_RES;
                if (stat.failed)                    val_next = 1'b0;
                else if (stat.n_is1 || stat.rd_zero) val_next = 1'b1;
                else if (stat.rd_gt1)               val_next = 1'b0;
                else begin
                    cmd.op     = OP_PINIT;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.scan_cont) begin
                    cmd.op = OP_PINC;
                end else begin
                    scan_next  = 1'b1;
                    state_next = S_RES;
                end
            end
            S_RES: begin
                if (!stat.out_busy) begin
                    cmd.op      = OP_RESULT;
                    cmd.res_val = scan_reg ? stat.rd_le0 : val_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            val_reg   <= 1'b0;
            scan_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            val_reg   <= val_next;
            scan_reg  <= scan_next;
        end
    end

endmodule

[sv/bcvd_dp.sv]
// ---------------------------------------------------------------------------
// BFB count vector decider datapath
// Signature registers with one read port, fold arithmetic, result register.
// ---------------------------------------------------------------------------
`include "bfb_count_vector_decider_assert.svh"

module bcvd_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [bcvd_pkg::COUNT_BITS-1:0] count,
    input  logic                           last,
    input  bcvd_pkg::cmd_t                 cmd,
    output bcvd_pkg::stat_t                stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           admits
);
    import bcvd_pkg::*;

    logic signed [SIG_W-1:0] sig_reg [SIG_DEPTH];
    logic [CW-1:0]           top_reg;
    logic [COUNT_BITS-1:0]   prev_reg;
    logic                    failed_reg;
    logic [COUNT_BITS-1:0]   n_reg;
    logic                    last_reg;
    logic [CW-1:0]           d_reg, d_next;
    logic [CW-1:0]           dv_reg;
    logic signed [DW-1:0]    delta_reg, delta_next;
    logic signed [DW-1:0]    tmp_reg;
    logic                    ge_reg;
    logic                    m_tvalid_reg;
    logic                    admits_reg;

    logic [COUNT_BITS-1:0]   diff;
    logic [CW-1:0]           dv_c;
    logic [CW-1:0]           rd_addr;
    logic signed [SIG_W-1:0] rd;
    logic signed [DW-1:0]    rd_x, nx, mul_d, t1;
    logic signed [SIG_W:0]   s1;
    logic [SIG_W-1:0]        s1_pos;
    logic [CW-1:0]           d_p1;
    logic                    wr_en;
    logic [CW-1:0]           wr_addr;
    logic signed [SIG_W-1:0] wr_data;

    assign diff = (prev_reg > n_reg) ? prev_reg - n_reg : n_reg - prev_reg;
    assign dv_c = tz(diff);
    assign d_p1 = d_reg + CW'(1);

    always_comb begin
        case (cmd.rsel)
            RS_DM1:   rd_addr = d_reg - CW'(1);
            RS_TOP:   rd_addr = top_reg;
            RS_TOPM1: rd_addr = top_reg - CW'(1);
            RS_ZERO:  rd_addr = '0;
            default:  rd_addr = d_reg;
        endcase
    end

    assign rd     = (rd_addr < CW'(SIG_DEPTH)) ? sig_reg[rd_addr[IW-1:0]] : '0;
    assign rd_x   = {{(DW-SIG_W){rd[SIG_W-1]}}, rd};
    assign nx     = signed'({{(DW-COUNT_BITS){1'b0}}, n_reg});
    assign mul_d  = mulp(absv(rd), d_reg);
    assign t1     = delta_reg + mul_d - nx;
    assign s1     = {rd[SIG_W-1], rd} + (SIG_W+1)'(1);
    assign s1_pos = (s1 > 0) ? s1[SIG_W-1:0] : '0;

    always_comb begin
        stat.eq        = (prev_reg == n_reg);
        stat.up        = (prev_reg < n_reg);
        stat.bad       = ({1'b0, dv_c} + (CW+1)'(1) >= (CW+1)'(SIG_DEPTH))
                         || (top_reg >= CW'(SIG_DEPTH));
        stat.r_lt_dv   = (top_reg < dv_c);
        stat.d_gt_dv   = (d_reg > dv_reg);
        stat.d_eq_dv   = (d_reg == dv_reg);
        stat.d_zero    = (d_reg == '0);
        stat.brk       = (nx >= mulp(s1_pos, d_reg) + delta_reg);
        stat.top_gt0   = (top_reg != '0);
        stat.rd_zero   = (rd == '0);
        stat.rd_le0    = (rd <= 0);
        stat.rd_gt1    = (rd > 1);
        stat.n_is1     = (n_reg == COUNT_BITS'(1));
        stat.scan_cont = (d_reg <= top_reg) && (d_reg < CW'(SIG_DEPTH)) && (rd == '0);
        stat.ge        = ge_reg;
        stat.failed    = failed_reg;
        stat.last      = last_reg;
        stat.out_busy  = m_tvalid_reg;
    end

    // single write port into the signature
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = d_reg;
        wr_data = '0;
        case (cmd.op)
            OP_ZERO: begin
                wr_en = 1'b1;
            end
            OP_ADJ: begin
                wr_en   = 1'b1;
                wr_data = sat(rd_x + ((d_reg == dv_reg) ? DW'(1) : DW'(2)));
            end
            OP_WR: begin
                wr_en = 1'b1;
                if (ge_reg) begin
                    wr_addr = d_p1;
                    wr_data = sat(divp(tmp_reg, d_p1));
                end else begin
                    wr_data = sat(divp(tmp_reg, d_reg));
                end
            end
            OP_WRZ: begin
                wr_en   = 1'b1;
                wr_addr = d_p1;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        d_next     = d_reg;
        delta_next = delta_reg;
        case (cmd.op)
            OP_START: begin
                d_next     = top_reg + CW'(1);
                delta_next = signed'({{(DW-COUNT_BITS){1'b0}}, prev_reg});
            end
            OP_ZERO:  if (d_reg != dv_reg) d_next = d_p1;
            OP_SUB: begin
                d_next     = d_reg - CW'(1);
                delta_next = delta_reg - mulp(absv(rd), rd_addr);
            end
            OP_PINIT: d_next = CW'(1);
            OP_PINC:  d_next = d_p1;
            default:  d_next = d_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        d_reg     <= d_next;
        delta_reg <= delta_next;
        if (cmd.op == OP_LOAD) begin
            n_reg    <= count;
            last_reg <= last;
        end
        if (cmd.op == OP_START) dv_reg <= dv_c;
        if (cmd.op == OP_UPNUM) begin
            tmp_reg <= t1;
            ge_reg  <= 1'b1;
        end else if (cmd.op == OP_CMP) begin
            tmp_reg <= (t1 <= 0) ? t1 : delta_reg - nx;
            ge_reg  <= (t1 <= 0);
        end
        if (cmd.op == OP_RESULT) admits_reg <= cmd.res_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.op == OP_RESULT) begin
            for (int i = 0; i < SIG_DEPTH; i++) sig_reg[i] <= '0;
            top_reg    <= '0;
            prev_reg   <= '0;
            failed_reg <= 1'b0;
        end else begin
            if (wr_en) sig_reg[wr_addr[IW-1:0]] <= wr_data;
            case (cmd.op)
                OP_SETTOP:  top_reg    <= d_p1;
                OP_TRIMDEC: top_reg    <= top_reg - CW'(1);
                OP_FAIL:    failed_reg <= 1'b1;
                OP_FINISH:  prev_reg   <= n_reg;
                default:    top_reg    <= top_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_RESULT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign admits   = admits_reg;

    `BCVD_ASSERT(a_top_range, top_reg < CW'(SIG_DEPTH), "top index out of range")
    `BCVD_ASSERT(a_no_wr_failed, wr_en |-> !failed_reg, "signature write after failure")
    `BCVD_ASSERT(a_sub_nonzero, (cmd.op == OP_SUB) |-> (d_reg != '0), "walk below entry zero")
    `BCVD_ASSERT(a_clear_on_res, (cmd.op == OP_RESULT) |=> (top_reg == '0 && !failed_reg && m_tvalid_reg), "state not cleared after result")

endmodule

[sv/bfb_count_vector_decider.sv]
// ---------------------------------------------------------------------------
// BFB count vector decider
// Folds copy counts into a signed signature and gives a one-bit verdict.
// ---------------------------------------------------------------------------
//  channel | dir | ports                             | word
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast | count, tlast = last
//  m_      | out | m_tvalid m_tready m_tdata         | admits, one per vector
//
// A count equal to the previous one, or after a failure, goes from S_START to
// S_FIN; any other walks down from top index r or clears up to dv, dv being
// the trailing zeros of the count difference, below COUNT_BITS. The walk down
// steps once per cycle; search and trim loops alternate S_SRCH/S_SRCHS and
// S_TRIMA/S_TRIMB. The last count adds a scan and any wait for the output
// register. Reset is synchronous and clears the signature at once.
// s_tready is high only while idle; a result waits in the output register.
module bfb_count_vector_decider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] count
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] admits, [7:1] zero
);
    import bcvd_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  admits;

    bcvd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bcvd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .count    (s_tdata[COUNT_BITS-1:0]),
        .last     (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .admits   (admits)
    );

    assign m_tdata = {7'd0, admits};

endmodule
